>>> sv/ocqs_pkg.sv
// Package for the OLED command queue sequencer.
// Holds sizes, codes, item and result types and the init and window tables.
// No dependencies.
package ocqs_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int MAX_GROUP   = 8;
  localparam int INIT_LEN    = 29;
  localparam int WIN_LEN     = 6;
  localparam int CMD_LANES   = 8;

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int GRP_W  = $clog2(MAX_GROUP + 1);
  localparam int LANE_W = $clog2(CMD_LANES);
  localparam int INIT_W = $clog2(INIT_LEN);
  localparam int WIN_W  = $clog2(WIN_LEN);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_DONE  = 2'd1,
    CMD_QUEUE = 2'd2,
    CMD_FRAME = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    PH_POR0  = 3'd0,
    PH_POR1  = 3'd1,
    PH_IDLE  = 3'd2,
    PH_CMD   = 3'd3,
    PH_FRAME = 3'd4
  } ph_e;

  typedef enum logic [2:0] {
    BK_WAIT = 3'd0,
    BK_EXEC = 3'd1,
    BK_PUSH = 3'd2,
    BK_READ = 3'd3,
    BK_DONE = 3'd4
  } bk_state_e;

  typedef struct packed {
    cmd_e                        kind;
    logic                        oversize;
    logic [GRP_W-1:0]            cnt;
    logic [CMD_LANES-1:0][7:0]   bytes;
    logic [15:0]                 len;
    logic                        link;
  } item_t;

  typedef struct packed {
    logic        status;
    logic        cs;
    logic        cvalid;
    logic [7:0]  cbyte;
    logic        dstart;
    logic [15:0] dlen;
  } res_t;

  localparam logic [7:0] INIT_SEQ [INIT_LEN] = '{
    8'hAE, 8'hD5, 8'hF0, 8'hA8, 8'h3F, 8'hD3, 8'h00, 8'h40, 8'hA6, 8'hA4,
    8'hA1, 8'hC8, 8'hDA, 8'h12, 8'h81, 8'hBF, 8'hD9, 8'h25, 8'hDB, 8'h34,
    8'h20, 8'h00, 8'h21, 8'h00, 8'h7F, 8'h22, 8'h00, 8'h07, 8'hAF
  };

  localparam logic [7:0] WIN_SEQ [WIN_LEN] = '{
    8'h21, 8'h00, 8'h7F, 8'h22, 8'h00, 8'h07
  };

  function automatic logic [7:0] init_byte(input logic [ADDR_W-1:0] a);
    logic [7:0] b;
    b = 8'h00;
    if (int'(a) < INIT_LEN) b = INIT_SEQ[a[INIT_W-1:0]];
    return b;
  endfunction

  function automatic logic [7:0] win_byte(input logic [WIN_W-1:0] i);
    logic [7:0] b;
    b = 8'h00;
    if (int'(i) < WIN_LEN) b = WIN_SEQ[i];
    return b;
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    logic [ADDR_W-1:0] n;
    n = (p == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : p + ADDR_W'(1);
    return n;
  endfunction

endpackage

>>> sv/ocqs_front.sv
// Front end: accepts input beats, classifies them and holds them in a
// two-entry queue for the back end. Depends on ocqs_pkg.
module ocqs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic [63:0]        cmd_bytes_i,
  input  logic [15:0]        length_i,
  input  logic               link_ready_i,
  output ocqs_pkg::item_t    item_o,
  output logic               item_valid_o,
  input  logic               pop_i
);

  ocqs_pkg::item_t ent_q [2];
  ocqs_pkg::item_t new_item;
  logic            wp_q, wp_d, rp_q, rp_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push, pop;

  always_comb begin
    new_item.kind     = ocqs_pkg::cmd_e'(command_i);
    new_item.oversize = (length_i > 16'(ocqs_pkg::MAX_GROUP));
    new_item.cnt      = length_i[ocqs_pkg::GRP_W-1:0];
    new_item.bytes    = cmd_bytes_i;
    new_item.len      = length_i;
    new_item.link     = link_ready_i;
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = pop_i && item_valid_o;
  assign item_o       = ent_q[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wp_q] <= new_item;
  end

endmodule

>>> sv/ocqs_back.sv
// Back end: sequencer state, command byte store and the output register.
// Carries out one queued item at a time. Depends on ocqs_pkg.
module ocqs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ocqs_pkg::item_t    item_i,
  input  logic               item_valid_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               status_o,
  output logic               ready_res_o,
  output logic               reset_pin_o,
  output logic               power_pin_o,
  output logic               cs_release_o,
  output logic               cmd_valid_o,
  output logic [7:0]         cmd_byte_o,
  output logic               dma_start_o,
  output logic [15:0]        dma_length_o
);

  localparam int ADDR_W = ocqs_pkg::ADDR_W;
  localparam int FILL_W = ocqs_pkg::FILL_W;
  localparam int GRP_W  = ocqs_pkg::GRP_W;

  ocqs_pkg::bk_state_e st_q, st_d;
  ocqs_pkg::ph_e       phase_q, phase_d;
  logic [ADDR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [FILL_W-1:0]   fill_q, fill_d, free;
  logic [15:0]         pend_q, pend_d;
  logic [1:0]          pins_q, pins_d;
  ocqs_pkg::item_t     it_q, it_d;
  logic [GRP_W-1:0]    idx_q, idx_d, cnt_q, cnt_d;
  ocqs_pkg::res_t      res_q, res_d, out_res_q, out_res_d;
  logic                out_valid_q, out_valid_d, out_rdy_q, out_rdy_d;
  logic [1:0]          out_pins_q, out_pins_d;
  logic                is_ready;

  logic [7:0]             mem_q [ocqs_pkg::QUEUE_DEPTH];
  logic [ocqs_pkg::QUEUE_DEPTH-1:0] vld_q;
  logic                   mem_we, rd_en;
  logic [7:0]             wbyte, rd_data_q, rd_init_q;
  logic                   rd_vld_q;

  assign free     = FILL_W'(ocqs_pkg::QUEUE_DEPTH) - fill_q;
  assign is_ready = (phase_q == ocqs_pkg::PH_IDLE) && (fill_q == '0) && (pend_q == '0);

  always_comb begin
    st_d        = st_q;
    phase_d     = phase_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    pend_d      = pend_q;
    pins_d      = pins_q;
    it_d        = it_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_res_d   = out_res_q;
    out_rdy_d   = out_rdy_q;
    out_pins_d  = out_pins_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    wbyte       = 8'h00;
    pop_o       = 1'b0;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    case (st_q)
      ocqs_pkg::BK_WAIT: begin
        if (item_valid_i) begin
          pop_o = 1'b1;
          it_d  = item_i;
          st_d  = ocqs_pkg::BK_EXEC;
        end
      end
      ocqs_pkg::BK_EXEC: begin
        res_d = '0;
        st_d  = ocqs_pkg::BK_DONE;
        case (it_q.kind)
          ocqs_pkg::CMD_TICK: begin
            case (phase_q)
              ocqs_pkg::PH_POR0: begin
                pins_d  = 2'b00;
                phase_d = ocqs_pkg::PH_POR1;
              end
              ocqs_pkg::PH_POR1: begin
                pins_d  = 2'b11;
                phase_d = ocqs_pkg::PH_IDLE;
              end
              ocqs_pkg::PH_IDLE: begin
                if (it_q.link) begin
                  if (fill_q != '0) begin
                    rd_en        = 1'b1;
                    res_d.cvalid = 1'b1;
                    fill_d       = fill_q - FILL_W'(1);
                    head_d       = ocqs_pkg::ptr_inc(head_q);
                    phase_d      = ocqs_pkg::PH_CMD;
                    st_d         = ocqs_pkg::BK_READ;
                  end else if (pend_q != '0) begin
                    res_d.dstart = 1'b1;
                    res_d.dlen   = pend_q;
                    pend_d       = '0;
                    phase_d      = ocqs_pkg::PH_FRAME;
                  end
                end
              end
              default: ;
            endcase
          end
          ocqs_pkg::CMD_DONE: begin
            if (phase_q inside {ocqs_pkg::PH_CMD, ocqs_pkg::PH_FRAME}) begin
              res_d.cs = 1'b1;
              phase_d  = ocqs_pkg::PH_IDLE;
            end
          end
          ocqs_pkg::CMD_QUEUE: begin
            if (it_q.oversize || (FILL_W'(it_q.cnt) > free)) begin
              res_d.status = 1'b1;
            end else if (it_q.cnt != '0) begin
              fill_d = fill_q + FILL_W'(it_q.cnt);
              cnt_d  = it_q.cnt;
              idx_d  = '0;
              st_d   = ocqs_pkg::BK_PUSH;
            end
          end
          ocqs_pkg::CMD_FRAME: begin
            if (!is_ready) begin
              res_d.status = 1'b1;
            end else begin
              fill_d = fill_q + FILL_W'(ocqs_pkg::WIN_LEN);
              pend_d = it_q.len;
              cnt_d  = GRP_W'(ocqs_pkg::WIN_LEN);
              idx_d  = '0;
              st_d   = ocqs_pkg::BK_PUSH;
            end
          end
          default: ;
        endcase
      end
      ocqs_pkg::BK_PUSH: begin
        mem_we = 1'b1;
        wbyte  = (it_q.kind == ocqs_pkg::CMD_FRAME)
               ? ocqs_pkg::win_byte(idx_q[ocqs_pkg::WIN_W-1:0])
               : it_q.bytes[idx_q[ocqs_pkg::LANE_W-1:0]];
        tail_d = ocqs_pkg::ptr_inc(tail_q);
        idx_d  = idx_q + GRP_W'(1);
        if (idx_q == cnt_q - GRP_W'(1)) st_d = ocqs_pkg::BK_DONE;
      end
      ocqs_pkg::BK_READ: begin
        res_d.cbyte = rd_vld_q ? rd_data_q : rd_init_q;
        st_d        = ocqs_pkg::BK_DONE;
      end
      ocqs_pkg::BK_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_rdy_d   = is_ready;
          out_pins_d  = pins_q;
          st_d        = ocqs_pkg::BK_WAIT;
        end
      end
      default: st_d = ocqs_pkg::BK_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ocqs_pkg::BK_WAIT;
      phase_q     <= ocqs_pkg::PH_POR0;
      head_q      <= '0;
      tail_q      <= ADDR_W'(ocqs_pkg::INIT_LEN % ocqs_pkg::QUEUE_DEPTH);
      fill_q      <= FILL_W'(ocqs_pkg::INIT_LEN);
      pend_q      <= '0;
      pins_q      <= 2'b00;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      pins_q      <= pins_d;
      out_valid_q <= out_valid_d;
      if (mem_we) vld_q[tail_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q       <= it_d;
    idx_q      <= idx_d;
    cnt_q      <= cnt_d;
    res_q      <= res_d;
    out_res_q  <= out_res_d;
    out_rdy_q  <= out_rdy_d;
    out_pins_q <= out_pins_d;
  end

  // byte store: entries not yet written read as the init sequence
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[tail_q] <= wbyte;
    if (rd_en) begin
      rd_data_q <= mem_q[head_q];
      rd_init_q <= ocqs_pkg::init_byte(head_q);
      rd_vld_q  <= vld_q[head_q];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_res_q.status;
  assign ready_res_o  = out_rdy_q;
  assign reset_pin_o  = out_pins_q[0];
  assign power_pin_o  = out_pins_q[1];
  assign cs_release_o = out_res_q.cs;
  assign cmd_valid_o  = out_res_q.cvalid;
  assign cmd_byte_o   = out_res_q.cbyte;
  assign dma_start_o  = out_res_q.dstart;
  assign dma_length_o = out_res_q.dlen;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(ocqs_pkg::QUEUE_DEPTH))
    else $error("fill count above queue depth");

  a_push_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ocqs_pkg::BK_PUSH) |-> (cnt_q != '0) && (idx_q < cnt_q))
    else $error("push index out of range");

  a_pins_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == ocqs_pkg::PH_IDLE || phase_q == ocqs_pkg::PH_CMD ||
     phase_q == ocqs_pkg::PH_FRAME) |-> (pins_q == 2'b11))
    else $error("panel lines low after power-on");

  a_pend_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != '0) |-> (phase_q != ocqs_pkg::PH_POR0) && (phase_q != ocqs_pkg::PH_POR1))
    else $error("frame pending before power-on done");

  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ocqs_pkg::BK_DONE) |-> !(res_q.cvalid && res_q.dstart))
    else $error("byte send and frame start on one beat");
`endif

endmodule

>>> sv/oled_command_queue_sequencer.sv
// Top level of the OLED command queue sequencer.
// Instantiates ocqs_front and ocqs_back; depends on ocqs_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one beat per request:
//   tick, transfer complete, queue command bytes or send frame. Output
//   channel (out_valid_o / out_stall_i) returns exactly one result beat
//   per input beat, in order.
//   Path: a beat passes through the front queue entry, then the back
//   end's wait, execute and done states and the output register; a tick
//   that sends a queued byte adds the read state for the store read, and
//   a queue or frame request adds the push state, which writes each byte
//   in turn (up to 8, or 6 for the window command). The back end works on
//   one beat at a time and takes no new beat until the last one is done.
//   A two-entry front queue keeps accepting while the back end works;
//   in_stall_o rises when it is full. When out_stall_i holds a result,
//   the back end finishes the next beat and waits.
//   Reset: panel lines low, power-on step zero, the byte store reads as
//   the 29-byte init sequence through per-entry valid bits (no clearing
//   pass), both channels empty.
module oled_command_queue_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [63:0] cmd_bytes_i,
  input  logic [15:0] length_i,
  input  logic        link_ready_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic        ready_res_o,
  output logic        reset_pin_o,
  output logic        power_pin_o,
  output logic        cs_release_o,
  output logic        cmd_valid_o,
  output logic [7:0]  cmd_byte_o,
  output logic        dma_start_o,
  output logic [15:0] dma_length_o
);

  ocqs_pkg::item_t item;
  logic            item_valid, pop;

  ocqs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .cmd_bytes_i  (cmd_bytes_i),
    .length_i     (length_i),
    .link_ready_i (link_ready_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .pop_i        (pop)
  );

  ocqs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .ready_res_o  (ready_res_o),
    .reset_pin_o  (reset_pin_o),
    .power_pin_o  (power_pin_o),
    .cs_release_o (cs_release_o),
    .cmd_valid_o  (cmd_valid_o),
    .cmd_byte_o   (cmd_byte_o),
    .dma_start_o  (dma_start_o),
    .dma_length_o (dma_length_o)
  );

endmodule
